// ===== sv/frustum_plane_cull_test_assert.svh =====
// Assertion macros for the RTL.
`ifndef FRUSTUM_PLANE_CULL_TEST_ASSERT_SVH
`define FRUSTUM_PLANE_CULL_TEST_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked only out of reset.
`define FPCT_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define FPCT_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FPCT_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define FPCT_ASSERT(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/fpct_pkg.sv =====
package fpct_pkg;

  localparam int COEF_W  = 32;
  localparam int EPS_W   = 31;
  localparam int RAD_W   = 31;
  localparam int THR_W   = 32;
  localparam int PROD_W  = 64;
  localparam int SUM_W   = 66;
  localparam int DIST_W  = 51;
  localparam int FRAC_W  = 16;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_POINT  = 2'd1;
  localparam logic [1:0] MODE_SPHERE = 2'd2;

  // Register index (paddr word address bits).
  localparam logic [PADDR_W-3:0] REG_EPSILON = '0;

  localparam logic [EPS_W-1:0] EPS_RESET = 31'd327680;

  typedef logic signed [COEF_W-1:0] coef_t;

  // Plane write request from the input stage to the lanes.
  typedef struct packed {
    logic       en;
    logic [2:0] idx;
    coef_t      a;
    coef_t      b;
    coef_t      c;
    coef_t      d;
  } plane_wr_t;

endpackage

// ===== sv/fpct_item_if.sv =====
interface fpct_item_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [2:0]         plane_index;
  logic signed [31:0] coef_a;
  logic signed [31:0] coef_b;
  logic signed [31:0] coef_c;
  logic signed [31:0] coef_d;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic [30:0]        radius;

  modport source (
    output valid, mode, plane_index, coef_a, coef_b, coef_c, coef_d,
           point_x, point_y, point_z, radius,
    input  ready
  );
  modport sink (
    input  valid, mode, plane_index, coef_a, coef_b, coef_c, coef_d,
           point_x, point_y, point_z, radius,
    output ready
  );
endinterface

// ===== sv/fpct_res_if.sv =====
interface fpct_res_if;
  logic       valid;
  logic       ready;
  logic       inside_res;
  logic [2:0] reject_plane;

  modport source (output valid, inside_res, reject_plane, input ready);
  modport sink   (input valid, inside_res, reject_plane, output ready);
endinterface

// ===== sv/fpct_lane.sv =====
// One plane: coefficient storage, product stage, distance stage, compare.
module fpct_lane #(
  parameter int LANE_ID = 0
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  fpct_pkg::plane_wr_t         wr,
  input  fpct_pkg::coef_t             pt_x,
  input  fpct_pkg::coef_t             pt_y,
  input  fpct_pkg::coef_t             pt_z,
  input  logic [fpct_pkg::THR_W-1:0]  thr,
  output logic                        rej
);
  import fpct_pkg::*;

  coef_t coef_a_r, coef_b_r, coef_c_r, coef_d_r;
  logic  hit;

  logic signed [PROD_W-1:0] pa_nxt, pb_nxt, pc_nxt;
  logic signed [PROD_W-1:0] pa_r, pb_r, pc_r;
  coef_t                    d_r;
  logic signed [SUM_W-1:0]  sum;
  logic signed [DIST_W-1:0] dist_nxt, dist_r;

  assign hit = wr.en && (wr.idx == 3'(LANE_ID));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r <= '0;
      coef_b_r <= '0;
      coef_c_r <= '0;
      coef_d_r <= '0;
    end else if (hit) begin
      coef_a_r <= wr.a;
      coef_b_r <= wr.b;
      coef_c_r <= wr.c;
      coef_d_r <= wr.d;
    end
  end

  // Exact Q32.32 products.
  assign pa_nxt = coef_a_r * pt_x;
  assign pb_nxt = coef_b_r * pt_y;
  assign pc_nxt = coef_c_r * pt_z;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
      pc_r <= pc_nxt;
      d_r  <= coef_d_r;
    end
  end

  // Floor of the exact sum to Q16.16, then add d.
  assign sum      = SUM_W'(pa_r) + SUM_W'(pb_r) + SUM_W'(pc_r);
  assign dist_nxt = DIST_W'(sum >>> FRAC_W) + DIST_W'(d_r);

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= dist_nxt;
    end
  end

  assign rej = dist_r > signed'({{(DIST_W-THR_W){1'b0}}, thr});

endmodule

// ===== sv/frustum_plane_cull_test.sv =====
// Frustum cull test: holds NUM_PLANES planes (Q16.16 a, b, c, d) and checks points or
// spheres against all of them in parallel, one item per clock unless the output stalls.
// A load item (mode 0) writes the plane at plane_index and gives no result; an index
// past the last plane, and mode 3, are dropped. A point (mode 1) or sphere (mode 2) item
// gives one result: inside_res, and reject_plane = lowest plane whose distance
// a*x+b*y+c*z+d (products exact, sum floored to Q16.16) exceeds the epsilon slack, plus
// radius for a sphere, or NUM_PLANES if none does. After the input register, the result
// passes the lane pipeline: 32x32 multipliers, then the distance adder, then the compare
// and priority pick into the result register. Back-to-back items are taken every cycle;
// the whole pipeline stalls only while a result is held at the output. A load takes
// effect for every item behind it. The epsilon slack register (reset 5.0) sits at byte
// address 0 of the APB port and should be written only while the block is idle. Planes
// reset to zero; no clearing pass is needed.
module frustum_plane_cull_test #(
  parameter int NUM_PLANES = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  fpct_item_if.sink                     in_chan,
  fpct_res_if.source                    out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fpct_pkg::PADDR_W-1:0]  paddr,
  input  logic [fpct_pkg::PDATA_W-1:0]  pwdata,
  output logic [fpct_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import fpct_pkg::*;

  `include "frustum_plane_cull_test_assert.svh"

  // ---------------- config register ----------------
  logic [EPS_W-1:0] eps_r;
  logic             eps_sel;

  assign pready  = 1'b1;
  assign eps_sel = (paddr[PADDR_W-1:2] == REG_EPSILON);
  assign prdata  = eps_sel ? PDATA_W'(eps_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (psel && penable && pwrite && pready && eps_sel) begin
      eps_r <= pwdata[EPS_W-1:0];
    end
  end

  // ---------------- pipeline enable ----------------
  // Every stage moves together; a held result stalls everything.
  logic en;
  logic out_vld_r;

  assign en            = !out_vld_r || out_chan.ready;
  assign in_chan.ready = en;

  // ---------------- stage 0: input register ----------------
  logic             s0_vld_r;
  logic [1:0]       s0_mode_r;
  logic [2:0]       s0_idx_r;
  coef_t            s0_a_r, s0_b_r, s0_c_r, s0_d_r;
  coef_t            s0_x_r, s0_y_r, s0_z_r;
  logic [RAD_W-1:0] s0_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_mode_r <= in_chan.mode;
      s0_idx_r  <= in_chan.plane_index;
      s0_a_r    <= in_chan.coef_a;
      s0_b_r    <= in_chan.coef_b;
      s0_c_r    <= in_chan.coef_c;
      s0_d_r    <= in_chan.coef_d;
      s0_x_r    <= in_chan.point_x;
      s0_y_r    <= in_chan.point_y;
      s0_z_r    <= in_chan.point_z;
      s0_rad_r  <= in_chan.radius;
    end
  end

  // Loads write the plane as they leave stage 0, so the next item sees them.
  plane_wr_t wr;
  logic      s0_test;

  always_comb begin
    wr.en  = en && s0_vld_r && (s0_mode_r == MODE_LOAD) && (int'(s0_idx_r) < NUM_PLANES);
    wr.idx = s0_idx_r;
    wr.a   = s0_a_r;
    wr.b   = s0_b_r;
    wr.c   = s0_c_r;
    wr.d   = s0_d_r;
  end

  assign s0_test = s0_vld_r && ((s0_mode_r == MODE_POINT) || (s0_mode_r == MODE_SPHERE));

  // ---------------- stages 1 and 2: threshold and valid ----------------
  logic             s1_vld_r, s2_vld_r;
  logic [THR_W-1:0] thr_nxt, s1_thr_r, s2_thr_r;

  assign thr_nxt = THR_W'(eps_r)
                 + ((s0_mode_r == MODE_SPHERE) ? THR_W'(s0_rad_r) : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= s0_test;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_thr_r <= thr_nxt;
      s2_thr_r <= s1_thr_r;
    end
  end

  // ---------------- plane lanes ----------------
  logic [NUM_PLANES-1:0] rej;

  for (genvar k = 0; k < NUM_PLANES; k++) begin : g_lane
    fpct_lane #(
      .LANE_ID (k)
    ) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .wr    (wr),
      .pt_x  (s0_x_r),
      .pt_y  (s0_y_r),
      .pt_z  (s0_z_r),
      .thr   (s2_thr_r),
      .rej   (rej[k])
    );
  end

  // Lowest rejecting plane wins.
  logic [2:0] rej_idx;

  always_comb begin
    rej_idx = 3'(NUM_PLANES);
    for (int k = NUM_PLANES - 1; k >= 0; k--) begin
      if (rej[k]) begin
        rej_idx = 3'(k);
      end
    end
  end

  // ---------------- result register ----------------
  logic       inside_r;
  logic [2:0] reject_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inside_r <= ~|rej;
      reject_r <= rej_idx;
    end
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.inside_res   = inside_r;
  assign out_chan.reject_plane = reject_r;

  // ---------------- assertions ----------------
  `FPCT_ASSERT_RST(a_load_no_result, clk, rst_n, (en && s0_vld_r && (s0_mode_r == MODE_LOAD)) |=> !s1_vld_r, "load item entered the test pipeline")
  `FPCT_ASSERT_RST(a_stall_holds, clk, rst_n, !en |=> ($stable(s1_vld_r) && $stable(s2_vld_r)), "pipeline moved during a stall")
  `FPCT_ASSERT_RST(a_inside_code, clk, rst_n, (out_vld_r && inside_r) |-> (reject_r == 3'(NUM_PLANES)), "inside result with a rejecting plane")
  `FPCT_ASSERT(a_reset_empty, clk, !rst_n |=> (!s0_vld_r && !s1_vld_r && !s2_vld_r && !out_vld_r), "pipeline not empty after reset")

endmodule

// ===== bench/frustum_plane_cull_test_tb.sv =====
`timescale 1ns / 1ps

module tb;
  import fpct_pkg::*;

  localparam int PLANES = 6;
  localparam logic [PADDR_W-1:0] EPS_ADDR = {REG_EPSILON, 2'b00};

  // One item on the input channel, all fields driven every time.
  typedef struct {
    logic [1:0]  mode;
    logic [2:0]  idx;
    coef_t       a;
    coef_t       b;
    coef_t       c;
    coef_t       d;
    coef_t       x;
    coef_t       y;
    coef_t       z;
    logic [30:0] radius;
  } cull_item_t;

  // One cull verdict as it should appear on the result channel.
  typedef struct {
    logic       pass_all;
    logic [2:0] reject_idx;
  } cull_res_t;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  fpct_item_if in_chan ();
  fpct_res_if  out_chan ();

  frustum_plane_cull_test #(.NUM_PLANES(PLANES)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Shadow copy of the plane store and the epsilon register.
  coef_t       plane_coef [PLANES][4];
  logic [30:0] eps_q;

  // Verdicts waiting for the result channel, oldest first.
  cull_res_t   cull_expect [$];

  int errors;
  int useful_items;   // loads to a real plane and point/sphere tests taken so far
  int ready_hold;     // cycles the result side still holds ready low
  bit hurry;          // when set, neither side idles

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Hard stop in case the handshake locks up or results go missing.
  initial begin
    #5_000_000;
    $display("** frustum_plane_cull_test: FAILED **");
    $finish;
  end

  function automatic int draw_wait();
    return hurry ? 0 : $urandom_range(0, 15);
  endfunction

  // a*x + b*y + c*z exact, floored to Q16.16, then d added; 68 bits never overflow.
  function automatic logic signed [67:0] signed_distance(int k, coef_t x, coef_t y,
                                                        coef_t z);
    logic signed [67:0] ca, cb, cc, cd, px, py, pz, sum;
    ca  = plane_coef[k][0];
    cb  = plane_coef[k][1];
    cc  = plane_coef[k][2];
    cd  = plane_coef[k][3];
    px  = x;
    py  = y;
    pz  = z;
    sum = ca * px + cb * py + cc * pz;
    return (sum >>> 16) + cd;
  endfunction

  // Applies one accepted item to the shadow state; queues a verdict for tests.
  function automatic void cull_predict(cull_item_t it);
    logic signed [67:0] thr;
    cull_res_t          res;
    case (it.mode)
      MODE_LOAD: begin
        if (it.idx < PLANES) begin
          plane_coef[it.idx][0] = it.a;
          plane_coef[it.idx][1] = it.b;
          plane_coef[it.idx][2] = it.c;
          plane_coef[it.idx][3] = it.d;
          useful_items++;
        end
      end
      MODE_POINT, MODE_SPHERE: begin
        thr = {37'd0, eps_q};
        if (it.mode == MODE_SPHERE)
          thr = thr + {37'd0, it.radius};
        res.pass_all   = 1'b1;
        res.reject_idx = 3'(PLANES);
        for (int k = 0; k < PLANES; k++) begin
          if (res.pass_all && signed_distance(k, it.x, it.y, it.z) > thr) begin
            res.pass_all   = 1'b0;
            res.reject_idx = 3'(k);
          end
        end
        cull_expect.push_back(res);
        useful_items++;
      end
      default: ;  // unused mode: dropped by the block
    endcase
  endfunction

  // Drives one item and waits for it to be taken. valid stays high on exit so a
  // back-to-back item follows without a bubble.
  task automatic send_item(cull_item_t it);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.mode        <= it.mode;
    in_chan.plane_index <= it.idx;
    in_chan.coef_a      <= it.a;
    in_chan.coef_b      <= it.b;
    in_chan.coef_c      <= it.c;
    in_chan.coef_d      <= it.d;
    in_chan.point_x     <= it.x;
    in_chan.point_y     <= it.y;
    in_chan.point_z     <= it.z;
    in_chan.radius      <= it.radius;
    do @(posedge clk); while (!in_chan.ready);
    cull_predict(it);
  endtask

  // Stops input and waits until every verdict is back and loads have retired.
  task automatic drain();
    in_chan.valid <= 1'b0;
    while (cull_expect.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Setup phase then access phase; returns prdata of the access phase.
  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= EPS_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata    = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Epsilon only changes with the block idle; bit 31 of the word is dropped.
  task automatic set_epsilon(logic [31:0] word);
    logic [31:0] rd;
    drain();
    apb_access(1'b1, word, rd);
    eps_q = word[30:0];
    @(posedge clk);
    apb_access(1'b0, 32'd0, rd);
    if (rd !== {1'b0, eps_q}) begin
      $display("%0t: epsilon readback: expected %h, got %h", $time, {1'b0, eps_q}, rd);
      errors++;
    end
  endtask

  function automatic cull_item_t raw_item();
    cull_item_t it;
    it.mode   = 2'($urandom_range(0, 3));
    it.idx    = 3'($urandom);
    it.a      = $urandom;
    it.b      = $urandom;
    it.c      = $urandom;
    it.d      = $urandom;
    it.x      = $urandom;
    it.y      = $urandom;
    it.z      = $urandom;
    it.radius = 31'($urandom);
    return it;
  endfunction

  // Face of an axis-aligned box of half-size half, normal slightly tilted:
  // planes 0/1 face +x/-x, 2/3 +y/-y, 4/5 +z/-z.
  function automatic cull_item_t box_plane(int k, int half);
    cull_item_t it;
    coef_t      n [3];
    int         sgn;
    it  = raw_item();
    sgn = (k % 2) ? -1 : 1;
    for (int i = 0; i < 3; i++)
      n[i] = (i == k / 2) ? sgn * (65536 + int'($urandom_range(0, 16384)) - 8192)
                          : int'($urandom_range(0, 8192)) - 4096;
    it.mode = MODE_LOAD;
    it.idx  = 3'(k);
    it.a    = n[0];
    it.b    = n[1];
    it.c    = n[2];
    it.d    = -half + int'($urandom_range(0, 131072)) - 65536;
    return it;
  endfunction

  // Point or sphere around the box, often straddling one face; now and then
  // full-range coordinates.
  function automatic cull_item_t box_probe(int span, int half);
    cull_item_t it;
    it      = raw_item();
    it.mode = $urandom_range(0, 1) ? MODE_SPHERE : MODE_POINT;
    if ($urandom_range(0, 9) != 0) begin
      it.x      = int'($urandom_range(0, 2 * span)) - span;
      it.y      = int'($urandom_range(0, 2 * span)) - span;
      it.z      = int'($urandom_range(0, 2 * span)) - span;
      it.radius = 31'($urandom_range(0, half / 2));
    end
    return it;
  endfunction

  // Result side: draws a stall after each result, checks every result taken.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (cull_expect.size() == 0) begin
        $display("%0t: result with nothing expected: inside=%0b reject_plane=%0d",
                 $time, out_chan.inside_res, out_chan.reject_plane);
        errors++;
      end else begin
        cull_res_t exp_res;
        exp_res = cull_expect.pop_front();
        if (out_chan.inside_res !== exp_res.pass_all ||
            out_chan.reject_plane !== exp_res.reject_idx) begin
          $display("%0t: mismatch: expected inside=%0b reject_plane=%0d, got inside=%0b reject_plane=%0d",
                   $time, exp_res.pass_all, exp_res.reject_idx,
                   out_chan.inside_res, out_chan.reject_plane);
          errors++;
        end
      end
      ready_hold = draw_wait();
    end
    if (ready_hold > 0) begin
      out_chan.ready <= 1'b0;
      ready_hold--;
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // After reset: epsilon reads 5.0 and zero planes pass anything.
  task automatic test_reset_state();
    logic [31:0] rd;
    cull_item_t  it;
    apb_access(1'b0, 32'd0, rd);
    if (rd !== {1'b0, EPS_RESET}) begin
      $display("%0t: epsilon after reset: expected %h, got %h", $time,
               {1'b0, EPS_RESET}, rd);
      errors++;
    end
    it = raw_item();
    it.mode = MODE_POINT;
    it.x = 32'sh8000_0000;  it.y = 32'sh8000_0000;  it.z = 32'sh8000_0000;
    send_item(it);
    it.x = 32'sh7FFF_FFFF;  it.y = 32'sh7FFF_FFFF;  it.z = 32'sh7FFF_FFFF;
    send_item(it);
    it.mode = MODE_SPHERE;
    it.radius = '1;
    send_item(it);
  endtask

  // Threshold edges, flooring of negative sums, dropped items, then extremes.
  task automatic test_boundaries();
    cull_item_t it;
    // plane 0: distance = x exactly
    it = raw_item();
    it.mode = MODE_LOAD;  it.idx = 3'd0;
    it.a = 32'sd65536;  it.b = '0;  it.c = '0;  it.d = '0;
    send_item(it);
    it.mode = MODE_POINT;
    it.x = coef_t'(eps_q);  it.y = 32'sh7FFF_FFFF;  it.z = 32'sh8000_0000;
    send_item(it);                                   // equal to epsilon: passes
    it.x = coef_t'(eps_q) + 1;
    send_item(it);                                   // one LSB over: plane 0 rejects
    it.mode = MODE_SPHERE;  it.radius = 31'd1;
    send_item(it);                                   // radius absorbs it
    // plane 1: tiny product rounds toward minus infinity
    it.mode = MODE_LOAD;  it.idx = 3'd1;
    it.a = 32'sd1;  it.b = '0;  it.c = '0;  it.d = coef_t'(eps_q) + 1;
    send_item(it);
    it.mode = MODE_POINT;  it.x = -32'sd1;
    send_item(it);                                   // floor(-1/2^16) = -1: passes
    it.x = 32'sd1;
    send_item(it);                                   // floor(1/2^16) = 0: plane 1 rejects
    // out-of-range plane index and mode 3 leave everything alone
    it.mode = MODE_LOAD;  it.idx = 3'd6;  it.d = 32'sh7FFF_FFFF;
    send_item(it);
    it.idx = 3'd7;
    send_item(it);
    it.mode = 2'd3;
    send_item(it);
    it.mode = MODE_POINT;  it.x = '0;
    send_item(it);
    // every plane at extreme coefficients
    for (int k = 0; k < PLANES; k++) begin
      it.mode = MODE_LOAD;  it.idx = 3'(k);
      it.a = 32'sh7FFF_FFFF;
      it.b = 32'sh8000_0000;
      it.c = (k % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      it.d = (k < 3) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      send_item(it);
    end
    it.mode = MODE_POINT;
    it.x = 32'sh8000_0000;  it.y = 32'sh7FFF_FFFF;  it.z = 32'sh8000_0000;
    send_item(it);
    it.mode = MODE_SPHERE;  it.radius = '1;
    it.x = 32'sh7FFF_FFFF;  it.y = 32'sh8000_0000;  it.z = 32'sh7FFF_FFFF;
    send_item(it);
  endtask

  // Box-shaped frustums with probes near the faces, a new epsilon per phase.
  task automatic test_box_frustums(int target);
    cull_item_t it;
    int         first, half, span, r;
    first = useful_items;
    while (useful_items - first < target) begin
      hurry = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 4))
        0:       set_epsilon(32'd0);
        1:       set_epsilon(32'h7FFF_FFFF);
        2:       set_epsilon({1'b0, EPS_RESET});
        3:       set_epsilon({1'($urandom), 31'($urandom_range(0, 20 * 65536))});
        default: set_epsilon($urandom);
      endcase
      half = $urandom_range(65536, 64 * 65536);
      span = half / 10 * 13;
      for (int k = 0; k < PLANES; k++)
        if ($urandom_range(0, 5) != 0)
          send_item(box_plane(k, half));
      repeat ($urandom_range(10, 60)) begin
        r = $urandom_range(0, 19);
        if (r == 0)
          it = raw_item();                             // noise, any mode
        else if (r == 1)
          it = box_plane($urandom_range(0, PLANES - 1), half);  // reload mid-stream
        else
          it = box_probe(span, half);
        send_item(it);
      end
    end
  endtask

  // Fully random items: random planes, random points, dropped items mixed in.
  task automatic test_raw_items(int target);
    int first;
    first = useful_items;
    set_epsilon($urandom);
    while (useful_items - first < target) begin
      if ($urandom_range(0, 49) == 0)
        hurry = ~hurry;
      send_item(raw_item());
    end
  endtask

  initial begin
    errors       = 0;
    useful_items = 0;
    ready_hold   = 0;
    hurry        = 1'b0;
    eps_q        = EPS_RESET;
    foreach (plane_coef[k, j])
      plane_coef[k][j] = '0;

    rst_n               <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_chan.valid       <= 1'b0;
    in_chan.mode        <= MODE_LOAD;
    in_chan.plane_index <= '0;
    in_chan.coef_a      <= '0;
    in_chan.coef_b      <= '0;
    in_chan.coef_c      <= '0;
    in_chan.coef_d      <= '0;
    in_chan.point_x     <= '0;
    in_chan.point_y     <= '0;
    in_chan.point_z     <= '0;
    in_chan.radius      <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_boundaries();
    test_box_frustums(1500);
    test_raw_items(250);

    drain();
    if (errors == 0)
      $display("** frustum_plane_cull_test: PASSED **");
    else
      $display("** frustum_plane_cull_test: FAILED **");
    $finish;
  end

endmodule
